>>> sv/mou_pkg.sv
// ----------------------------------------------------------------------------
// mou_pkg
// Widths and reset constants shared by the multiplicative order unit.
// ----------------------------------------------------------------------------
package mou_pkg;

  localparam int MOD_BITS = 31;
  localparam int D_BITS = (MOD_BITS + 1) / 2 + 1;
  localparam int CNT_BITS = $clog2(MOD_BITS);
  localparam logic [MOD_BITS-1:0] BASE_RESET = MOD_BITS'(10);

endpackage

>>> sv/multiplicative_order_unit.sv
// ----------------------------------------------------------------------------
// multiplicative_order_unit
// Euler totient of a modulus and multiplicative order of a base modulo it.
// ----------------------------------------------------------------------------
//  channel   ports                         transaction at
//  command   start, busy, modulus          start && !busy
//  result    done, order, phi              done (one cycle)
//  config    wr_en, wr_data                wr_en
//
//  One transaction's length is data dependent, shortest for moduli below
//  two: every trial divisor costs one pass of the shared restoring divider,
//  and every exponent bit costs one or two shift-add modular multiplies.
//  busy stays high from the accepted command until the result cycle ends.
//  Reset is synchronous; it returns base to 10 and the sequencer to idle.
//  The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module multiplicative_order_unit
  import mou_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MOD_BITS-1:0] modulus,
  output logic                done,
  output logic [MOD_BITS-1:0] order,
  output logic [MOD_BITS-1:0] phi,
  input  logic                wr_en,
  input  logic [MOD_BITS-1:0] wr_data
);

  localparam int W = MOD_BITS;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] T_SQ    = 5'd1;
  localparam logic [4:0] T_CHK   = 5'd2;
  localparam logic [4:0] T_R1    = 5'd3;
  localparam logic [4:0] T_AM    = 5'd4;
  localparam logic [4:0] T_AW    = 5'd5;
  localparam logic [4:0] T_ST    = 5'd6;
  localparam logic [4:0] T_TAIL  = 5'd7;
  localparam logic [4:0] T_TM    = 5'd8;
  localparam logic [4:0] T_TW    = 5'd9;
  localparam logic [4:0] O_INIT  = 5'd10;
  localparam logic [4:0] R_INIT  = 5'd11;
  localparam logic [4:0] R_SQ    = 5'd12;
  localparam logic [4:0] R_CHK   = 5'd13;
  localparam logic [4:0] R_R1    = 5'd14;
  localparam logic [4:0] R_PW    = 5'd15;
  localparam logic [4:0] P_START = 5'd16;
  localparam logic [4:0] P_INIT  = 5'd17;
  localparam logic [4:0] P_LOOP  = 5'd18;
  localparam logic [4:0] P_SQ1   = 5'd19;
  localparam logic [4:0] P_SQ    = 5'd20;
  localparam logic [4:0] P_SQW   = 5'd21;
  localparam logic [4:0] R_PC    = 5'd22;
  localparam logic [4:0] R_ST    = 5'd23;
  localparam logic [4:0] R_TAIL  = 5'd24;
  localparam logic [4:0] R_TPW   = 5'd25;
  localparam logic [4:0] R_TC    = 5'd26;
  localparam logic [4:0] R_END   = 5'd27;
  localparam logic [4:0] S_DONE  = 5'd28;
  localparam logic [4:0] S_DIV   = 5'd29;
  localparam logic [4:0] S_MM    = 5'd30;

  localparam logic [W-1:0] ONE = W'(1);

  logic [4:0]          state;
  logic [4:0]          ret;
  logic [W-1:0]        base;
  logic [W-1:0]        n;
  logic [W-1:0]        rest;
  logic [W-1:0]        acc;
  logic [W-1:0]        phi_r;
  logic [W-1:0]        t;
  logic [W-1:0]        pick;
  logic [W-1:0]        cand;
  logic [W-1:0]        e;
  logic                tail;
  logic [D_BITS-1:0]   d;
  logic [W-1:0]        pacc;
  logic [W-1:0]        pb;
  logic [2*W-1:0]      prod;
  logic [W-1:0]        dq;
  logic [W-1:0]        dr;
  logic [W-1:0]        dd;
  logic [CNT_BITS-1:0] cnt;
  logic [W-1:0]        mr;
  logic [W-1:0]        ma;
  logic [W-1:0]        mb;

  logic [W-1:0]        dw;
  logic [W-1:0]        mul_a;
  logic [W-1:0]        mul_b;
  logic [W:0]          trial;
  logic                tbit;
  logic [W-1:0]        dr_next;
  logic [W:0]          r2;
  logic [W:0]          r2m;
  logic [W:0]          r3;
  logic [W:0]          r3m;

  assign dw = {{(W-D_BITS){1'b0}}, d};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      T_SQ, R_SQ: begin
        mul_a = dw;
        mul_b = dw;
      end
      T_AM: begin
        mul_a = dq;
        mul_b = dw - ONE;
      end
      T_TM: begin
        mul_a = dq;
        mul_b = rest - ONE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    trial = {dr, dq[W-1]};
    tbit = trial >= {1'b0, dd};
    dr_next = tbit ? W'(trial - {1'b0, dd}) : trial[W-1:0];
  end

  always_comb begin
    r2 = {mr, 1'b0};
    r2m = (r2 >= {1'b0, n}) ? r2 - {1'b0, n} : r2;
    r3 = r2m + (ma[W-1] ? {1'b0, mb} : '0);
    r3m = (r3 >= {1'b0, n}) ? r3 - {1'b0, n} : r3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      base <= BASE_RESET;
    end else begin
      if (wr_en) begin
        base <= wr_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            n <= modulus;
            rest <= modulus;
            acc <= modulus;
            d <= D_BITS'(2);
            state <= T_SQ;
          end
        end
        T_SQ: begin
          prod <= {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
          state <= T_CHK;
        end
        T_CHK: begin
          if (prod > {{W{1'b0}}, rest}) begin
            state <= T_TAIL;
          end else begin
            dq <= rest; dr <= '0; dd <= dw; cnt <= CNT_BITS'(W - 1);
            ret <= T_R1; state <= S_DIV;
          end
        end
        T_R1: begin
          if (dr == '0) begin
            dq <= acc; dr <= '0; dd <= dw; cnt <= CNT_BITS'(W - 1);
            ret <= T_AM; state <= S_DIV;
          end else begin
            d <= d + 1'b1;
            state <= T_SQ;
          end
        end
        T_AM: begin
          prod <= {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
          state <= T_AW;
        end
        T_AW: begin
          acc <= prod[W-1:0];
          dq <= rest; dr <= '0; dd <= dw; cnt <= CNT_BITS'(W - 1);
          ret <= T_ST; state <= S_DIV;
        end
        T_ST: begin
          if (dr == '0) begin
            rest <= dq;
            dr <= '0; dd <= dw; cnt <= CNT_BITS'(W - 1);
            ret <= T_ST; state <= S_DIV;
          end else begin
            d <= d + 1'b1;
            state <= T_SQ;
          end
        end
        T_TAIL: begin
          if (rest > ONE) begin
            dq <= acc; dr <= '0; dd <= rest; cnt <= CNT_BITS'(W - 1);
            ret <= T_TM; state <= S_DIV;
          end else begin
            state <= O_INIT;
          end
        end
        T_TM: begin
          prod <= {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
          state <= T_TW;
        end
        T_TW: begin
          acc <= prod[W-1:0];
          state <= O_INIT;
        end
        O_INIT: begin
          phi_r <= acc;
          t <= acc;
          state <= (n > ONE) ? R_INIT : S_DONE;
        end
        R_INIT: begin
          rest <= t;
          pick <= t;
          d <= D_BITS'(2);
          state <= R_SQ;
        end
        R_SQ: begin
          prod <= {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
          state <= R_CHK;
        end
        R_CHK: begin
          if (prod > {{W{1'b0}}, rest}) begin
            state <= R_TAIL;
          end else begin
            dq <= rest; dr <= '0; dd <= dw; cnt <= CNT_BITS'(W - 1);
            ret <= R_R1; state <= S_DIV;
          end
        end
        R_R1: begin
          if (dr == '0) begin
            dq <= t; dr <= '0; dd <= dw; cnt <= CNT_BITS'(W - 1);
            ret <= R_PW; state <= S_DIV;
          end else begin
            d <= d + 1'b1;
            state <= R_SQ;
          end
        end
        R_PW: begin
          cand <= dq;
          e <= dq;
          tail <= 1'b0;
          state <= P_START;
        end
        P_START: begin
          dq <= base; dr <= '0; dd <= n; cnt <= CNT_BITS'(W - 1);
          ret <= P_INIT; state <= S_DIV;
        end
        P_INIT: begin
          pb <= dr;
          pacc <= ONE;
          state <= P_LOOP;
        end
        P_LOOP: begin
          if (e == '0) begin
            state <= tail ? R_TC : R_PC;
          end else if (e[0]) begin
            mr <= '0; ma <= pacc; mb <= pb; cnt <= CNT_BITS'(W - 1);
            ret <= P_SQ1; state <= S_MM;
          end else begin
            state <= P_SQ;
          end
        end
        P_SQ1: begin
          pacc <= mr;
          state <= P_SQ;
        end
        P_SQ: begin
          mr <= '0; ma <= pb; mb <= pb; cnt <= CNT_BITS'(W - 1);
          ret <= P_SQW; state <= S_MM;
        end
        P_SQW: begin
          pb <= mr;
          e <= e >> 1;
          state <= P_LOOP;
        end
        R_PC: begin
          if (pacc == ONE) begin
            pick <= cand;
          end
          dq <= rest; dr <= '0; dd <= dw; cnt <= CNT_BITS'(W - 1);
          ret <= R_ST; state <= S_DIV;
        end
        R_ST: begin
          if (dr == '0) begin
            rest <= dq;
            dr <= '0; dd <= dw; cnt <= CNT_BITS'(W - 1);
            ret <= R_ST; state <= S_DIV;
          end else begin
            d <= d + 1'b1;
            state <= R_SQ;
          end
        end
        R_TAIL: begin
          if (rest > ONE) begin
            dq <= t; dr <= '0; dd <= rest; cnt <= CNT_BITS'(W - 1);
            ret <= R_TPW; state <= S_DIV;
          end else begin
            state <= R_END;
          end
        end
        R_TPW: begin
          cand <= dq;
          e <= dq;
          tail <= 1'b1;
          state <= P_START;
        end
        R_TC: begin
          if (pacc == ONE) begin
            pick <= cand;
          end
          state <= R_END;
        end
        R_END: begin
          if (pick == t) begin
            state <= S_DONE;
          end else begin
            t <= pick;
            state <= R_INIT;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        S_DIV: begin
          dr <= dr_next;
          dq <= {dq[W-2:0], tbit};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ret;
          end
        end
        S_MM: begin
          mr <= r3m[W-1:0];
          ma <= ma << 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ret;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign order = t;
  assign phi = phi_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("sequencer not idle after result");

  a_order_le_phi: assert property (@(posedge clk) disable iff (rst)
    done |-> order <= phi) else $error("order exceeds totient");

endmodule
